// File: rtl/core/pksf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pksf_pkg
// Types and constants shared by the shift register scanner and its queue.
// ----------------------------------------------------------------------------
package pksf_pkg;

	localparam int unsigned BYTE_BITS = 8;

	localparam logic [7:0] SCAN_PERIOD_RESET = 8'd16;

	typedef logic [BYTE_BITS-1:0] byte_t;

	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_POP  = 1'b1
	} item_kind_t;

	// Byte handed from the scanner to the queue
	typedef struct packed {
		logic  valid;
		byte_t data;
	} push_req_t;

	// Queue status seen by the scanner and the top level
	typedef struct packed {
		logic  empty;
		logic  full;
		byte_t head_data;
	} queue_stat_t;

endpackage

// File: rtl/core/pksf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pksf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pksf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/pksf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pksf_queue
// Ring queue of scanned bytes. The RAM read address follows the next head
// pointer so the oldest byte is always ready in the registered read data.
// ----------------------------------------------------------------------------
module pksf_queue
	import pksf_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  push_req_t   push,
	input  logic        pop,
	output queue_stat_t stat
);

	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] head_d;
	logic [PTR_W-1:0] head_inc;
	logic [PTR_W-1:0] tail_inc;
	logic             pop_ok;
	logic             bypass_q;
	byte_t            bypass_data_q;
	byte_t            ram_rdata;

	assign head_inc = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;

	assign stat.empty = (head_q == tail_q);
	assign stat.full  = (tail_inc == head_q);

	assign pop_ok = pop && !stat.empty;
	assign head_d = pop_ok ? head_inc : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			bypass_q <= 1'b0;
		end else begin
			head_q   <= head_d;
			if (push.valid) begin
				tail_q <= tail_inc;
			end
			// a byte written to the slot being read lands too late for the RAM
			bypass_q <= push.valid && (tail_q == head_d);
		end
	end

	always_ff @(posedge clk) begin
		bypass_data_q <= push.data;
	end

	pksf_ram #(
		.WIDTH(BYTE_BITS),
		.DEPTH(FIFO_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (push.valid),
		.waddr(tail_q),
		.wdata(push.data),
		.raddr(head_d),
		.rdata(ram_rdata)
	);

	assign stat.head_data = bypass_q ? bypass_data_q : ram_rdata;

endmodule

// File: rtl/core/pksf_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pksf_scan
// Serial clock, load line and bit capture for the external shift register.
// ----------------------------------------------------------------------------
module pksf_scan
	import pksf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tick,
	input  logic        serial_in,
	input  logic [7:0]  scan_period,
	input  queue_stat_t qstat,
	output logic        clock_level,
	output logic        load_level,
	output logic        load_after_tick,
	output push_req_t   push
);

	localparam logic [3:0] BITS_FULL = 4'(BYTE_BITS);

	logic       clock_level_q;
	logic       load_level_q;
	logic [7:0] cycle_count_q;
	logic [3:0] bits_left_q;
	byte_t      shift_byte_q;

	logic       active;
	logic       load_d;
	logic [7:0] cycle_count_d;
	logic [3:0] bits_left_d;
	byte_t      shift_byte_d;
	logic [3:0] bits_now;
	logic [2:0] bit_idx;
	logic [8:0] count_inc;

	// work happens only on ticks where the clock is low
	assign active    = tick && !clock_level_q;
	assign bits_now  = (cycle_count_q == 8'd1) ? BITS_FULL : bits_left_q;
	assign bit_idx   = 3'(bits_now - 4'd1);
	assign count_inc = {1'b0, cycle_count_q} + 9'd1;

	always_comb begin
		load_d        = load_level_q;
		cycle_count_d = cycle_count_q;
		bits_left_d   = bits_left_q;
		shift_byte_d  = shift_byte_q;
		push.valid    = 1'b0;
		push.data     = shift_byte_q;
		if (active) begin
			load_d        = (cycle_count_q != 8'd0);
			cycle_count_d = (count_inc >= {1'b0, scan_period}) ? 8'd0 : count_inc[7:0];
			if (bits_now != 4'd0) begin
				shift_byte_d          = shift_byte_q;
				shift_byte_d[bit_idx] = shift_byte_q[bit_idx] | serial_in;
				bits_left_d           = bits_now - 4'd1;
			end else begin
				// drop the byte if zero or if the queue is full
				push.valid   = (shift_byte_q != '0) && !qstat.full;
				shift_byte_d = '0;
				bits_left_d  = bits_now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_level_q <= 1'b0;
			load_level_q  <= 1'b1;
			cycle_count_q <= '0;
			bits_left_q   <= '0;
			shift_byte_q  <= '0;
		end else begin
			if (tick) begin
				clock_level_q <= !clock_level_q;
			end
			load_level_q  <= load_d;
			cycle_count_q <= cycle_count_d;
			bits_left_q   <= bits_left_d;
			shift_byte_q  <= shift_byte_d;
		end
	end

	assign clock_level     = clock_level_q;
	assign load_level      = load_level_q;
	assign load_after_tick = load_d;

endmodule

// File: rtl/core/piso_key_scanner_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piso_key_scanner_fifo
// Scanner for an external parallel-in serial-out shift register with a queue.
// ----------------------------------------------------------------------------
// Items enter on the item channel (item_valid / item_stall): kind 0 is a timer
// tick carrying the serial_in level, kind 1 pops the oldest queued byte.
// Every item gives one transaction on the result channel (result_valid /
// result_stall) with the serial clock level, the load line and read_data.
// An accepted item sits in the input register until the output register can
// advance; that edge loads its result into the output register, and the
// result is offered from that edge on. One item per cycle is sustained
// while the receiver does not stall; the only per-item loop is the state
// update and one queue RAM access.
// When the receiver stalls, the output register holds its transaction and
// the input register still takes one more item before item_stall rises.
// scan_period is written through cfg_valid / cfg_ready / cfg_data; cfg_ready
// is always high. Write it only while no item is in flight.
// Reset clears the valid bits of both registers, the scan state and the queue
// pointers and sets scan_period to 16; queue contents are not cleared.
// ----------------------------------------------------------------------------
module piso_key_scanner_fifo
	import pksf_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       kind,
	input  logic       serial_in,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       clock_out,
	output logic       load_n_out,
	output logic [7:0] read_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic        s1_valid_s1;
	item_kind_t  kind_s1;
	logic        serial_in_s1;
	logic        result_valid_q;
	logic        clock_out_q;
	logic        load_n_out_q;
	byte_t       read_data_q;
	logic [7:0]  scan_period_q;

	logic        advance;
	logic        fire;
	logic        tick;
	logic        pop;
	logic        clock_level;
	logic        load_level;
	logic        load_after_tick;
	push_req_t   push;
	queue_stat_t qstat;

	assign advance    = !result_valid_q || !result_stall;
	assign fire       = s1_valid_s1 && advance;
	assign item_stall = s1_valid_s1 && !advance;
	assign tick       = fire && (kind_s1 == KIND_TICK);
	assign pop        = fire && (kind_s1 == KIND_POP);
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q <= SCAN_PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			scan_period_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			s1_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall) begin
			kind_s1      <= item_kind_t'(kind);
			serial_in_s1 <= serial_in;
		end
	end

	pksf_scan u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick           (tick),
		.serial_in      (serial_in_s1),
		.scan_period    (scan_period_q),
		.qstat          (qstat),
		.clock_level    (clock_level),
		.load_level     (load_level),
		.load_after_tick(load_after_tick),
		.push           (push)
	);

	pksf_queue #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.stat  (qstat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			clock_out_q  <= clock_level;
			load_n_out_q <= tick ? load_after_tick : load_level;
			read_data_q  <= (pop && !qstat.empty) ? qstat.head_data : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign clock_out    = clock_out_q;
	assign load_n_out   = load_n_out_q;
	assign read_data    = read_data_q;

	a_no_stall_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid_q |-> !item_stall)
		else $error("input stalled while output register is free");

	a_result_from_fire: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(fire))
		else $error("result appeared without a processed item");

	a_empty_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && qstat.empty) |=> (read_data_q == '0))
		else $error("pop of empty queue returned data");

	a_tick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> (read_data_q == '0))
		else $error("tick result carried read data");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shift register scanner and its byte queue.
// ----------------------------------------------------------------------------
// A queue of pending items, filled by the stimulus process, feeds a driver
// that changes inputs on the falling edge. On the rising edge every accepted
// item is run through a scanner predictor and the expected transaction is
// queued. Each result transaction is compared field by field with the oldest
// expected one. The run steps through several scan periods, including
// periods below the normal range and both ends of the 8-bit register, and
// varies the idle and stall rates on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import pksf_pkg::*;

	typedef struct {
		item_kind_t kind;
		logic       sin;
	} scan_item_t;

	typedef struct {
		logic  clock_out;
		logic  load_n_out;
		byte_t read_data;
	} scan_res_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	logic       kind = 1'b0;
	logic       serial_in = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic       clock_out;
	logic       load_n_out;
	logic [7:0] read_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = '0;

	scan_item_t pending_items[$];
	scan_res_t  expected_scans[$];
	int         err_count = 0;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	logic       item_taken = 1'b0;
	logic       hold_req = 1'b0;
	int         hold_left = 0;
	int         periods[9] = '{10, 0, 255, 5, 1, 16, 2, 9, 128};

	// Predictor state
	logic [7:0] period_q = SCAN_PERIOD_RESET;
	logic       sclk_lvl = 1'b0;
	logic       load_lvl = 1'b1;
	logic [7:0] scan_cnt = '0;
	logic [3:0] bits_left = '0;
	byte_t      shift_byte = '0;
	byte_t      queue_mem[8];
	logic [2:0] rd_ptr = '0;
	logic [2:0] wr_ptr = '0;

	scan_res_t  mon_exp;
	scan_res_t  mon_got;
	scan_item_t drv_next;

	piso_key_scanner_fifo u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.kind         (kind),
		.serial_in    (serial_in),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.clock_out    (clock_out),
		.load_n_out   (load_n_out),
		.read_data    (read_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	task automatic predict_scan(input item_kind_t k, input logic sin, output scan_res_t r);
		r.read_data = '0;
		if (k == KIND_TICK) begin
			r.clock_out = sclk_lvl;
			// Scan state moves only on ticks taken at low clock level
			if (!sclk_lvl) begin
				load_lvl = (scan_cnt != 8'd0);
				if (scan_cnt == 8'd1)
					bits_left = 4'd8;
				if (bits_left != 4'd0) begin
					shift_byte = shift_byte | (byte_t'(sin) << (bits_left - 4'd1));
					bits_left = bits_left - 4'd1;
				end else begin
					// Drop zero bytes and bytes arriving at a full queue
					if (shift_byte != '0 && (wr_ptr + 3'd1) != rd_ptr) begin
						queue_mem[wr_ptr] = shift_byte;
						wr_ptr = wr_ptr + 3'd1;
					end
					shift_byte = '0;
				end
				scan_cnt = ({1'b0, scan_cnt} + 9'd1 >= {1'b0, period_q}) ? 8'd0
					: scan_cnt + 8'd1;
			end
			sclk_lvl = ~sclk_lvl;
			r.load_n_out = load_lvl;
		end else begin
			if (rd_ptr != wr_ptr) begin
				r.read_data = queue_mem[rd_ptr];
				rd_ptr = rd_ptr + 3'd1;
			end
			r.clock_out = sclk_lvl;
			r.load_n_out = load_lvl;
		end
	endtask

	// Predict on accepted items, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				period_q = cfg_data;
			item_taken = item_valid && !item_stall;
			if (item_taken) begin
				predict_scan(item_kind_t'(kind), serial_in, mon_exp);
				expected_scans.push_back(mon_exp);
			end
			if (result_valid && !result_stall) begin
				mon_got.clock_out = clock_out;
				mon_got.load_n_out = load_n_out;
				mon_got.read_data = read_data;
				if (expected_scans.size() == 0) begin
					$error("unexpected result transaction: clock_out %0d load_n_out %0d read_data %0h",
						clock_out, load_n_out, read_data);
					err_count++;
				end else begin
					mon_exp = expected_scans.pop_front();
					if (mon_got.clock_out !== mon_exp.clock_out) begin
						$error("clock_out: expected %0d, got %0d", mon_exp.clock_out,
							mon_got.clock_out);
						err_count++;
					end
					if (mon_got.load_n_out !== mon_exp.load_n_out) begin
						$error("load_n_out: expected %0d, got %0d", mon_exp.load_n_out,
							mon_got.load_n_out);
						err_count++;
					end
					if (mon_got.read_data !== mon_exp.read_data) begin
						$error("read_data: expected %0h, got %0h", mon_exp.read_data,
							mon_got.read_data);
						err_count++;
					end
				end
			end
		end
	end

	// Item driver: advance only once the current transaction has gone
	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_taken)) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_next = pending_items.pop_front();
				item_valid <= 1'b1;
				kind <= drv_next.kind;
				serial_in <= drv_next.sin;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Result receiver, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 80;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic add_item(input item_kind_t k, input logic sin);
		scan_item_t it;
		it.kind = k;
		it.sin = sin;
		pending_items.push_back(it);
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || item_valid || expected_scans.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_period(input logic [7:0] value);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Runs of ticks with random, all-zero or all-one serial data, and pop bursts
	task automatic add_random(input int count);
		int left;
		int len;
		int mode;
		left = count;
		while (left > 0) begin
			if ($urandom_range(99) < 25) begin
				len = $urandom_range(1, 10);
				for (int i = 0; i < len && left > 0; i++, left--)
					add_item(KIND_POP, 1'($urandom_range(1)));
			end else begin
				len = $urandom_range(1, 80);
				mode = $urandom_range(9);
				for (int i = 0; i < len && left > 0; i++, left--)
					add_item(KIND_TICK, (mode < 7) ? 1'($urandom_range(1)) : (mode == 9));
			end
		end
	endtask

	initial begin
		byte_t pattern;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Pops on an empty queue, then one full scan at the reset period
		send_idle_pct = 21;
		recv_idle_pct = 68;
		add_item(KIND_POP, 1'b0);
		add_item(KIND_POP, 1'b1);
		pattern = 8'hA5;
		for (int t = 0; t < 19; t++) begin
			if (t[0] == 1'b0 && t / 2 >= 1 && t / 2 <= 8)
				add_item(KIND_TICK, pattern[8 - t / 2]);
			else
				add_item(KIND_TICK, t[1]);
		end
		add_item(KIND_POP, 1'b0);
		add_item(KIND_POP, 1'b1);

		for (int p = 0; p < 9; p++) begin
			write_period(8'(periods[p]));
			case (p / 3)
				0: begin send_idle_pct = 21; recv_idle_pct = 68; end
				1: begin send_idle_pct = 68; recv_idle_pct = 21; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			if (p == 6) begin
				// Hold the sender until every result is in
				add_random(60);
				wait_drained();
				add_random(65);
			end else begin
				add_random(125);
			end
			if (p == 4) begin
				while (pending_items.size() > 100)
					@(posedge clk);
				hold_req = 1'b1;
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
